FILE: rtl/olq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olq_pkg: shared definitions of the optical odometry lap qualifier
// Field widths, fixed-point settings, register indexes and the controller
// state type.
// ----------------------------------------------------------------------------
package olq_pkg;

	// Fixed-point settings of the distance path.
	localparam int FRAC_BITS = 8;
	localparam int SUM_WIDTH = 32;

	// Field widths.
	localparam int DELTA_W = 8;
	localparam int CYC_W   = 32;
	localparam int RATE_W  = 16;
	localparam int STEP_W  = 16;
	localparam int VEL_W   = 32;
	localparam int LAP_W   = 16;
	localparam int RUN_W   = 8;
	localparam int LIMIT_W = 15;

	// Square root: dx^2 + dy^2 fits 16 bits, scaled by 2^(2*FRAC_BITS).
	localparam int SQ_W   = 2 * DELTA_W;
	localparam int RAD_W  = SQ_W + 2 * FRAC_BITS;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 3;

	// Velocity: step times clock rate, then divided by the elapsed cycles.
	localparam int PROD_W = STEP_W + CYC_W;
	localparam int CNT_W  = $clog2(VEL_W);

	localparam logic [STEP_W-1:0] STEP_MAX = '1;
	localparam logic [RUN_W-1:0]  RUN_MAX  = '1;

	// Packed stream widths, rounded up to whole bytes.
	localparam int IN_BITS  = 2 * DELTA_W + CYC_W + RATE_W + 1;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = STEP_W + 32 + VEL_W + 1 + LAP_W + 1 + 1;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_RATE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_LIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_STRAIGHT = 2'd2;

	// Register reset values.
	localparam logic [31:0]        CLOCK_RATE_RST   = 32'd50000000;
	localparam logic [LIMIT_W-1:0] STRAIGHT_LIM_RST = 15'd2048;
	localparam logic [RUN_W-1:0]   MIN_STRAIGHT_RST = 8'd5;

	// Controller states.
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ROOT = 5'b00010,
		ST_CHK  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_HOLD = 5'b10000
	} state_t;

endpackage

FILE: rtl/optical_odometry_lap_qualifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// optical_odometry_lap_qualifier_top: lap qualifier for optical odometry
// Works out step distance, running distance and velocity of each motion
// sample and qualifies start-line crossings after a straight run.
// ----------------------------------------------------------------------------
// The block takes one sample at a time and returns one result for it. From
// acceptance to its result in the output register a sample passes through a
// two-bit-per-cycle square root (the clock-rate product is built up one root
// bit per cycle alongside), a step for the overflow check and the distance
// total, a one-bit-per-cycle restoring divider, and a hand-over step. With
// zero elapsed time or an overflowing velocity the divider is skipped. The
// next sample is accepted in the cycle after the result has moved into the
// output register, even if it has not yet been taken. A result still waiting
// in the output register holds the following one back in the hand-over cycle.
// Configuration writes must be made only while no sample is in flight; the
// block itself does not enforce this.
module optical_odometry_lap_qualifier_top
	import olq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_wdata,
	// Sample stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// delta_x[7:0], delta_y[15:8], elapsed_cycles[47:16], turn_rate[63:48],
	// line_seen[64], zero fill
	input  logic [IN_W-1:0]      s_tdata,
	// motion_valid[0]
	input  logic                 s_tuser,
	// Result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// step_distance[15:0], total_distance[47:16], velocity[79:48],
	// time_zero[80], lap_total[96:81], lap_crossed[97], detector_reset[98],
	// zero fill
	output logic [OUT_W-1:0]     m_tdata
);

	// Configuration registers
	logic [31:0]        clock_rate_q;
	logic [LIMIT_W-1:0] straight_lim_q;
	logic [RUN_W-1:0]   min_straight_q;

	// Persistent state
	logic [SUM_WIDTH-1:0] sum_q;
	logic [LAP_W-1:0]     laps_q;
	logic [RUN_W-1:0]     run_q;

	// Work registers
	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [RAD_W-1:0]    rad_q;
	logic [REM_W-1:0]    srem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [PROD_W-1:0]   prod_q;
	logic [CYC_W-1:0]    cyc_q;
	logic [CYC_W-1:0]    drem_q;
	logic [VEL_W-1:0]    quo_q;
	logic                tz_q;
	logic                crossed_q;
	logic                det_q;

	// Output register
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	// Input unpacking
	logic signed [DELTA_W-1:0] dx;
	logic signed [DELTA_W-1:0] dy;
	logic signed [SQ_W-1:0]    px;
	logic signed [SQ_W-1:0]    py;
	logic [SQ_W-1:0]           sq;
	logic [CYC_W-1:0]          in_cyc;
	logic [RATE_W-1:0]         in_rate;
	logic [RATE_W-1:0]         mag;
	logic                      in_line;
	logic                      straight;
	logic [RUN_W-1:0]          run_inc;
	logic                      qualified;
	logic                      crossing;
	logic                      accept;

	// Square root step
	logic [REM_W-1:0]    srem_sh;
	logic [REM_W-1:0]    strial;
	logic                sbit;

	// Step, total and overflow check
	logic [31:0]          root_ext;
	logic                 root_sat;
	logic [STEP_W-1:0]    step;
	logic [SUM_WIDTH:0]   sum_add;
	logic [SUM_WIDTH-1:0] sum_next;
	logic [PROD_W-1:0]    prod_fix;
	logic [CYC_W-1:0]     prod_hi;
	logic                 vel_ovf;
	logic [63:0]          sum_ext;
	logic [31:0]          total;

	// Divider step
	logic [CYC_W:0]       drem_sh;
	logic                 dbit;
	logic [CYC_W:0]       drem_sub;

	logic                 out_free;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// Sample fields; without motion the deltas and the time count as zero
	assign dx      = s_tuser ? s_tdata[DELTA_W-1:0] : '0;
	assign dy      = s_tuser ? s_tdata[2*DELTA_W-1:DELTA_W] : '0;
	assign in_cyc  = s_tuser ? s_tdata[2*DELTA_W+CYC_W-1:2*DELTA_W] : '0;
	assign in_rate = s_tdata[2*DELTA_W+CYC_W+RATE_W-1:2*DELTA_W+CYC_W];
	assign in_line = s_tdata[2*DELTA_W+CYC_W+RATE_W];

	// Squared length of the motion vector
	assign px = dx * dx;
	assign py = dy * dy;
	assign sq = unsigned'(px) + unsigned'(py);

	// Straight-run qualification, decided when the sample is accepted
	assign mag       = in_rate[RATE_W-1] ? RATE_W'(-in_rate) : in_rate;
	assign straight  = mag < RATE_W'(straight_lim_q);
	assign run_inc   = !straight ? '0 : (run_q == RUN_MAX) ? RUN_MAX : run_q + 1'b1;
	assign qualified = run_inc > min_straight_q;
	assign crossing  = qualified && in_line;

	// One step of the digit-by-digit square root
	assign srem_sh = {srem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
	assign strial  = REM_W'({root_q, 2'b01});
	assign sbit    = srem_sh >= strial;

	// Step distance saturates at the field width
	assign root_ext = 32'(root_q);
	assign root_sat = root_ext > 32'(STEP_MAX);
	assign step     = root_sat ? STEP_MAX : root_ext[STEP_W-1:0];

	// Saturating distance total; a crossing clears it after the add
	assign sum_add  = {1'b0, sum_q} + (SUM_WIDTH+1)'(step);
	assign sum_next = crossed_q ? '0 : sum_add[SUM_WIDTH] ? '1 : sum_add[SUM_WIDTH-1:0];
	assign sum_ext  = 64'(sum_q);
	assign total    = (sum_ext > 64'hFFFF_FFFF) ? '1 : sum_ext[31:0];

	// A saturated step multiplies as (rate << 16) - rate
	assign prod_fix = root_sat ? ((PROD_W'(clock_rate_q) << STEP_W) - PROD_W'(clock_rate_q))
		: prod_q;
	assign prod_hi  = CYC_W'(prod_fix[PROD_W-1:VEL_W]);
	assign vel_ovf  = prod_hi >= cyc_q;

	// One step of the restoring divider
	assign drem_sh  = {drem_q, quo_q[VEL_W-1]};
	assign dbit     = drem_sh >= {1'b0, cyc_q};
	assign drem_sub = drem_sh - {1'b0, cyc_q};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_rate_q   <= CLOCK_RATE_RST;
			straight_lim_q <= STRAIGHT_LIM_RST;
			min_straight_q <= MIN_STRAIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLOCK_RATE:   clock_rate_q   <= cfg_wdata;
				REG_STRAIGHT_LIM: straight_lim_q <= cfg_wdata[LIMIT_W-1:0];
				REG_MIN_STRAIGHT: min_straight_q <= cfg_wdata[RUN_W-1:0];
				default: ;
			endcase
		end
	end

	// Controller, persistent state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sum_q      <= '0;
			laps_q     <= '0;
			run_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// The output register fills on hand-over and empties when taken.
			if (state_q == ST_HOLD && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						run_q <= crossing ? '0 : run_inc;
						if (crossing) begin
							laps_q <= laps_q + 1'b1;
						end
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (cnt_q == '0) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					sum_q <= sum_next;
					if (tz_q || vel_ovf) begin
						state_q <= ST_HOLD;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: square root with product build-up, then division
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rad_q     <= {sq, (2*FRAC_BITS)'(0)};
					srem_q    <= '0;
					root_q    <= '0;
					prod_q    <= '0;
					cyc_q     <= in_cyc;
					tz_q      <= (in_cyc == '0);
					crossed_q <= crossing;
					det_q     <= !qualified || crossing;
					cnt_q     <= CNT_W'(ROOT_W - 1);
				end
			end
			ST_ROOT: begin
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				srem_q <= sbit ? srem_sh - strial : srem_sh;
				root_q <= {root_q[ROOT_W-2:0], sbit};
				prod_q <= {prod_q[PROD_W-2:0], 1'b0} + (sbit ? PROD_W'(clock_rate_q) : '0);
				cnt_q  <= cnt_q - 1'b1;
			end
			ST_CHK: begin
				drem_q <= prod_hi;
				cnt_q  <= CNT_W'(VEL_W - 1);
				if (tz_q) begin
					quo_q <= '0;
				end else if (vel_ovf) begin
					quo_q <= '1;
				end else begin
					quo_q <= prod_fix[VEL_W-1:0];
				end
			end
			ST_DIV: begin
				drem_q <= dbit ? drem_sub[CYC_W-1:0] : drem_sh[CYC_W-1:0];
				quo_q  <= {quo_q[VEL_W-2:0], dbit};
				cnt_q  <= cnt_q - 1'b1;
			end
			ST_HOLD: begin
				if (out_free) begin
					m_tdata_q <= OUT_W'({det_q, crossed_q, laps_q, tz_q, quo_q, total, step});
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// A crossing result reports a detector reset and a cleared total
	a_cross_clears : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[97]) |-> (m_tdata[98] && m_tdata[47:16] == 32'd0))
		else $error("crossing result without detector reset or cleared total");

	// Zero elapsed time always gives zero velocity
	a_tz_vel : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[80]) |-> (m_tdata[79:48] == 32'd0))
		else $error("time_zero result with non-zero velocity");

	// A sample is never followed by another in the very next cycle
	a_one_at_a_time : assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second sample accepted while one is in flight");

	// The lap count changes only by one, and only on an accepted sample
	a_lap_step : assert property (@(posedge clk) disable iff (!arst_n)
		(laps_q != $past(laps_q)) |-> ($past(accept) && laps_q == $past(laps_q) + 1'b1))
		else $error("lap count changed unexpectedly");

endmodule
